// ----- rtl/core/cst_pkg.sv -----
// Shared types and constants for the connection state tracker.
package cst_pkg;

  // Connection phases, encoded as reported on conn_state
  typedef enum logic [2:0] {
    PH_CLOSED    = 3'd0,
    PH_SYN_SENT  = 3'd1,
    PH_SYN_RCVD  = 3'd2,
    PH_ESTAB     = 3'd3,
    PH_FIN_WAIT  = 3'd4,
    PH_TIME_WAIT = 3'd5
  } phase_t;

  // Raw flag kind codes on the input request
  localparam logic [3:0] FK_SYN    = 4'd0;
  localparam logic [3:0] FK_SYNACK = 4'd1;
  localparam logic [3:0] FK_ACK    = 4'd2;
  localparam logic [3:0] FK_RST    = 4'd3;
  localparam logic [3:0] FK_PSHACK = 4'd6;
  localparam logic [3:0] FK_FIN    = 4'd7;

  // Flag kinds after classification; everything the machine ignores is K_OTHER
  typedef enum logic [2:0] {
    K_SYN    = 3'd0,
    K_SYNACK = 3'd1,
    K_ACK    = 3'd2,
    K_RST    = 3'd3,
    K_PSHACK = 3'd4,
    K_FIN    = 3'd5,
    K_OTHER  = 3'd6
  } kind_t;

  // Node role register values
  localparam logic [1:0] ROLE_FIRST  = 2'd0;
  localparam logic [1:0] ROLE_SECOND = 2'd1;
  localparam logic [1:0] ROLE_RESET  = 2'd2;

  // Configuration register byte addresses
  localparam logic [1:0] ADDR_NODE_ROLE = 2'd0;

  // Reject reasons
  localparam logic [1:0] RSN_NONE   = 2'd0;
  localparam logic [1:0] RSN_LENGTH = 2'd1;
  localparam logic [1:0] RSN_ACK    = 2'd2;

  // Connection flag bit positions
  localparam int FB_SYNACK_DONE  = 0;
  localparam int FB_ESTABLISHING = 1;
  localparam int FB_IS_ESTAB     = 2;
  localparam int FB_VERIFIED     = 3;
  localparam int FB_KILLED       = 4;
  localparam int FB_HARD_RESET   = 5;

  // Status byte codes
  localparam logic [7:0] ST_SYNACK_ONLY   = 8'h10;
  localparam logic [7:0] ST_OPENING       = 8'h90;
  localparam logic [7:0] ST_IDLE_ESTAB    = 8'hC0;
  localparam logic [7:0] ST_QUIET         = 8'h80;
  localparam logic [7:0] ST_SENDING       = 8'h40;
  localparam logic [7:0] ST_HARD_RESET    = 8'h20;
  localparam logic [7:0] ST_CLOSING       = 8'h08;
  localparam logic [7:0] ST_KILLED        = 8'h88;
  localparam logic [7:0] ST_CLOSED_KILLED = 8'h80;
  localparam logic [7:0] ST_NONE          = 8'h00;

  // Input request fields
  typedef struct packed {
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [15:0] payload_length;
    logic [3:0]  flag_kind;
    logic        retrans_expired;
    logic        wait_expired;
    logic        open_request;
    logic        close_request;
    logic        now_sending;
  } in_item_t;

  // Result fields
  typedef struct packed {
    logic        accepted;
    logic [1:0]  reject_reason;
    logic [2:0]  conn_state;
    logic [7:0]  status_byte;
    logic        restart_wait_timer;
    logic [31:0] seq_now;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [31:0] len_sum;
    kind_t       kind;
    logic        retrans_expired;
    logic        wait_expired;
    logic        open_request;
    logic        close_request;
    logic        now_sending;
  } q_item_t;

endpackage

// ----- rtl/core/cst_front.sv -----
// Front end: accepts requests, tracks the payload length and classifies flags.
module cst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cst_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output cst_pkg::q_item_t  push_data
);

  logic [15:0] last_length_r;
  logic [15:0] last_length_nxt;
  logic        accept;
  cst_pkg::kind_t kind;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Keep the last nonzero payload length
  always_comb begin
    last_length_nxt = last_length_r;
    if (in_data.payload_length != 16'd0) begin
      last_length_nxt = in_data.payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_length_r <= 16'd0;
    end else if (accept) begin
      last_length_r <= last_length_nxt;
    end
  end

  // Fold the raw flag kind onto the kinds the machine reacts to
  always_comb begin
    case (in_data.flag_kind)
      cst_pkg::FK_SYN:    kind = cst_pkg::K_SYN;
      cst_pkg::FK_SYNACK: kind = cst_pkg::K_SYNACK;
      cst_pkg::FK_ACK:    kind = cst_pkg::K_ACK;
      cst_pkg::FK_RST:    kind = cst_pkg::K_RST;
      cst_pkg::FK_PSHACK: kind = cst_pkg::K_PSHACK;
      cst_pkg::FK_FIN:    kind = cst_pkg::K_FIN;
      default:            kind = cst_pkg::K_OTHER;
    endcase
  end

  // Build the classified request, with the expected sequence precomputed
  always_comb begin
    push_data.seq_in          = in_data.seq_in;
    push_data.ack_in          = in_data.ack_in;
    push_data.len_sum         = in_data.ack_in + {16'd0, last_length_nxt};
    push_data.kind            = kind;
    push_data.retrans_expired = in_data.retrans_expired;
    push_data.wait_expired    = in_data.wait_expired;
    push_data.open_request    = in_data.open_request;
    push_data.close_request   = in_data.close_request;
    push_data.now_sending     = in_data.now_sending;
  end

endmodule

// ----- rtl/core/cst_queue.sv -----
// Two-entry queue between the front end and the connection machine.
module cst_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  cst_pkg::q_item_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output cst_pkg::q_item_t pop_data
);

  cst_pkg::q_item_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/cst_back.sv -----
// Back end: number checks, connection machine, status byte and result register.
module cst_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        node_role,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cst_pkg::q_item_t  pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cst_pkg::out_item_t out_data
);

  cst_pkg::phase_t phase_r;
  cst_pkg::phase_t phase_nxt;
  logic [31:0] seq_r;
  logic [31:0] ack_r;
  logic [5:0]  flags_r;
  logic [5:0]  flags_nxt;
  logic        open_r;
  logic        open_nxt;
  logic        out_valid_r;
  cst_pkg::out_item_t out_data_r;
  cst_pkg::out_item_t out_data_nxt;

  logic        step;
  logic        pend;
  logic [1:0]  reason;
  logic        pass;
  logic        restart;
  cst_pkg::kind_t kind;

  function automatic logic [7:0] status_of(input logic [5:0] f, input logic closing,
                                           input logic sending);
    logic ds, es, ie, iv, kd, hr;
    ds = f[cst_pkg::FB_SYNACK_DONE];
    es = f[cst_pkg::FB_ESTABLISHING];
    ie = f[cst_pkg::FB_IS_ESTAB];
    iv = f[cst_pkg::FB_VERIFIED];
    kd = f[cst_pkg::FB_KILLED];
    hr = f[cst_pkg::FB_HARD_RESET];
    if (ds && !es && !ie)                             status_of = cst_pkg::ST_SYNACK_ONLY;
    else if (!ds && es && !ie)                        status_of = cst_pkg::ST_OPENING;
    else if (ds && ie && !sending)                    status_of = cst_pkg::ST_IDLE_ESTAB;
    else if (ie && iv && !sending && !closing && !kd) status_of = cst_pkg::ST_QUIET;
    else if (ie && iv && sending && !closing)         status_of = cst_pkg::ST_SENDING;
    else if (hr)                                      status_of = cst_pkg::ST_HARD_RESET;
    else if (closing && !kd)                          status_of = cst_pkg::ST_CLOSING;
    else if (!closing && kd)                          status_of = cst_pkg::ST_KILLED;
    else if (closing && kd)                           status_of = cst_pkg::ST_CLOSED_KILLED;
    else                                              status_of = cst_pkg::ST_NONE;
  endfunction

  assign kind      = pop_data.kind;
  assign pop_ready = !out_valid_r || out_ready;
  assign step      = pop_valid && pop_ready;
  assign pend      = open_r || pop_data.open_request;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Check the packet numbers against the stored ones
  always_comb begin
    if (seq_r != 32'd0 && pop_data.len_sum != pop_data.seq_in) begin
      reason = cst_pkg::RSN_LENGTH;
    end else if (ack_r != 32'd0 && pop_data.ack_in != seq_r) begin
      reason = cst_pkg::RSN_ACK;
    end else begin
      reason = cst_pkg::RSN_NONE;
    end
  end

  assign pass = (reason == cst_pkg::RSN_NONE);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (pass) begin
      case (phase_r)
        cst_pkg::PH_CLOSED: begin
          if (kind == cst_pkg::K_SYN) begin
            phase_nxt = pend ? cst_pkg::PH_SYN_SENT : cst_pkg::PH_SYN_RCVD;
          end
        end
        cst_pkg::PH_SYN_SENT: begin
          if (pop_data.retrans_expired) phase_nxt = cst_pkg::PH_CLOSED;
          else if (kind == cst_pkg::K_SYN) phase_nxt = cst_pkg::PH_SYN_RCVD;
          else if (kind == cst_pkg::K_SYNACK) phase_nxt = cst_pkg::PH_ESTAB;
        end
        cst_pkg::PH_SYN_RCVD: begin
          if (kind == cst_pkg::K_PSHACK || kind == cst_pkg::K_ACK) begin
            phase_nxt = cst_pkg::PH_ESTAB;
          end else if (!pop_data.retrans_expired && kind == cst_pkg::K_RST) begin
            phase_nxt = cst_pkg::PH_CLOSED;
          end
        end
        cst_pkg::PH_ESTAB: begin
          if (kind == cst_pkg::K_FIN) phase_nxt = cst_pkg::PH_FIN_WAIT;
          else if (flags_r[cst_pkg::FB_HARD_RESET]) phase_nxt = cst_pkg::PH_TIME_WAIT;
          else if (kind == cst_pkg::K_RST) phase_nxt = cst_pkg::PH_TIME_WAIT;
          else if (pop_data.close_request) phase_nxt = cst_pkg::PH_FIN_WAIT;
        end
        cst_pkg::PH_FIN_WAIT: begin
          if (kind == cst_pkg::K_ACK) phase_nxt = cst_pkg::PH_TIME_WAIT;
        end
        cst_pkg::PH_TIME_WAIT: begin
          if (pop_data.wait_expired || kind == cst_pkg::K_ACK) begin
            phase_nxt = cst_pkg::PH_CLOSED;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Flags, pending open and timer restart for the step
  always_comb begin
    flags_nxt = flags_r;
    open_nxt  = pend;
    restart   = 1'b0;
    if (pass) begin
      case (phase_r)
        cst_pkg::PH_CLOSED: begin
          if (kind == cst_pkg::K_SYN && !pend) begin
            flags_nxt[cst_pkg::FB_ESTABLISHING] = 1'b1;
            flags_nxt[cst_pkg::FB_VERIFIED]     = 1'b1;
          end else if (kind == cst_pkg::K_SYN) begin
            open_nxt                           = 1'b0;
            flags_nxt[cst_pkg::FB_SYNACK_DONE] = 1'b1;
          end else begin
            flags_nxt[cst_pkg::FB_HARD_RESET] = 1'b1;
          end
        end
        cst_pkg::PH_SYN_SENT: begin
          if (!pop_data.retrans_expired && kind == cst_pkg::K_SYNACK) begin
            flags_nxt[cst_pkg::FB_IS_ESTAB] = 1'b1;
            flags_nxt[cst_pkg::FB_VERIFIED] = 1'b1;
          end
        end
        cst_pkg::PH_SYN_RCVD: begin
          if (kind == cst_pkg::K_PSHACK || kind == cst_pkg::K_ACK) begin
            if (node_role == cst_pkg::ROLE_SECOND) begin
              flags_nxt[cst_pkg::FB_ESTABLISHING] = 1'b0;
              flags_nxt[cst_pkg::FB_IS_ESTAB]     = 1'b1;
              flags_nxt[cst_pkg::FB_VERIFIED]     = 1'b1;
            end else if (node_role != cst_pkg::ROLE_FIRST &&
                         flags_r[cst_pkg::FB_ESTABLISHING]) begin
              flags_nxt[cst_pkg::FB_IS_ESTAB] = 1'b1;
              flags_nxt[cst_pkg::FB_VERIFIED] = 1'b1;
            end
          end else if (!pop_data.retrans_expired && kind == cst_pkg::K_RST) begin
            flags_nxt[cst_pkg::FB_IS_ESTAB] = 1'b0;
            flags_nxt[cst_pkg::FB_VERIFIED] = 1'b0;
          end
        end
        cst_pkg::PH_ESTAB: begin
          if (kind == cst_pkg::K_FIN) begin
            if (!pop_data.close_request) flags_nxt[cst_pkg::FB_KILLED] = 1'b1;
          end else if (flags_r[cst_pkg::FB_HARD_RESET]) begin
            flags_nxt[cst_pkg::FB_KILLED] = 1'b1;
            restart                       = 1'b1;
          end else if (kind == cst_pkg::K_RST) begin
            restart = 1'b1;
          end
        end
        cst_pkg::PH_FIN_WAIT: begin
          if (kind == cst_pkg::K_ACK) begin
            flags_nxt[cst_pkg::FB_KILLED] = 1'b1;
            restart                       = 1'b1;
          end
        end
        default: restart = 1'b0;
      endcase
    end
  end

  // Assemble the result
  always_comb begin
    out_data_nxt.accepted           = pass;
    out_data_nxt.reject_reason      = reason;
    out_data_nxt.conn_state         = phase_nxt;
    out_data_nxt.status_byte        = status_of(flags_nxt, pop_data.close_request,
                                                pop_data.now_sending);
    out_data_nxt.restart_wait_timer = restart;
    out_data_nxt.seq_now            = pass ? pop_data.seq_in : seq_r;
  end

  // Advance connection state on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cst_pkg::PH_CLOSED;
      seq_r   <= 32'd0;
      ack_r   <= 32'd0;
      flags_r <= 6'd0;
      open_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      open_r  <= open_nxt;
      if (pass) begin
        seq_r <= pop_data.seq_in;
        ack_r <= pop_data.seq_in;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/core/connection_state_tracker.sv -----
// Top level of the connection state tracker with its configuration port.
//
// Each received packet request yields one result: the packet's sequence and
// acknowledge numbers are checked against the stored ones, and on a match the
// six-state connection machine takes one step and reports its state, the
// diagnostic status byte and a time-wait restart pulse. Requests are taken one
// per cycle while the output is not stalled; a result passes through the
// two-entry queue and then the result register loaded by the connection
// machine before it is offered. While the output is stalled the result
// register and the queue absorb three requests before the input is held off.
// The node_role register sits at byte address 0; the user must write it only
// while idle, and the block itself does not enforce this.
module connection_state_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cst_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0] node_role_r;
  logic       push_valid;
  logic       push_ready;
  logic       pop_valid;
  logic       pop_ready;
  cst_pkg::q_item_t push_data;
  cst_pkg::q_item_t pop_data;

  assign pready = 1'b1;

  // Write the node role register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_role_r <= cst_pkg::ROLE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == cst_pkg::ADDR_NODE_ROLE) begin
      node_role_r <= pwdata[1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = 32'd0;
    if (paddr == cst_pkg::ADDR_NODE_ROLE) begin
      prdata = {30'd0, node_role_r};
    end
  end

  cst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .node_role (node_role_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb_connection_state_tracker.sv -----
// Self-checking testbench for the connection state tracker: directed and random packets.
`timescale 1ns / 1ps

module tb_connection_state_tracker;

  // Flag kinds the block folds into K_OTHER
  localparam logic [3:0] FLAG_FINACK  = 4'd4;
  localparam logic [3:0] FLAG_PSH     = 4'd5;
  localparam logic [3:0] FLAG_OTHER   = 4'd8;
  localparam logic [3:0] FLAG_OTHER2  = 4'd9;
  localparam logic [3:0] FLAG_UNKNOWN = 4'd10;
  localparam logic [3:0] FLAG_TOP     = 4'd15;

  // Node role value past the named ones
  localparam logic [1:0] ROLE_TOP = 2'd3;

  // Connection flag bits
  localparam logic [6:0] CF_SYNACK_DONE  = 7'h01;
  localparam logic [6:0] CF_ESTABLISHING = 7'h02;
  localparam logic [6:0] CF_IS_ESTAB     = 7'h04;
  localparam logic [6:0] CF_VERIFIED     = 7'h08;
  localparam logic [6:0] CF_KILLED       = 7'h10;
  localparam logic [6:0] CF_HARD_RESET   = 7'h20;

  // Control bit masks for directed requests: {retrans, wait, open, close, sending}
  localparam logic [4:0] CTL_NONE    = 5'b00000;
  localparam logic [4:0] CTL_SENDING = 5'b00001;
  localparam logic [4:0] CTL_CLOSE   = 5'b00010;
  localparam logic [4:0] CTL_OPEN    = 5'b00100;
  localparam logic [4:0] CTL_WAIT    = 5'b01000;
  localparam logic [4:0] CTL_RETRANS = 5'b10000;

  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;

  // Predicts the tracker's verdict per packet and checks the block's results
  class tracker_scoreboard;
    logic [1:0]         role;
    cst_pkg::phase_t    ph;
    logic [31:0]        seq_num;
    logic [31:0]        ack_num;
    logic [15:0]        last_len;
    logic [6:0]         cflags;
    bit                 open_pend;
    cst_pkg::out_item_t verdict_q[$];
    int                 errors;
    int                 checked;
    int                 n_stepped;
    int                 n_len_rej;
    int                 n_ack_rej;
    bit [7:0]           phases_seen;

    function new();
      role        = cst_pkg::ROLE_RESET;
      ph          = cst_pkg::PH_CLOSED;
      seq_num     = '0;
      ack_num     = '0;
      last_len    = '0;
      cflags      = '0;
      open_pend   = 1'b0;
      errors      = 0;
      checked     = 0;
      n_stepped   = 0;
      n_len_rej   = 0;
      n_ack_rej   = 0;
      phases_seen = '0;
    endfunction

    function bit has(logic [6:0] f);
      return (cflags & f) != 7'd0;
    endfunction

    // Priority-encode the status byte from the flags
    function logic [7:0] status_code(bit closing, bit sending);
      bit ds, es, ie, iv, kd, hr;
      ds = has(CF_SYNACK_DONE);
      es = has(CF_ESTABLISHING);
      ie = has(CF_IS_ESTAB);
      iv = has(CF_VERIFIED);
      kd = has(CF_KILLED);
      hr = has(CF_HARD_RESET);
      if (ds && !es && !ie) return cst_pkg::ST_SYNACK_ONLY;
      if (!ds && es && !ie) return cst_pkg::ST_OPENING;
      if (ds && ie && !sending) return cst_pkg::ST_IDLE_ESTAB;
      if (ie && iv && !sending && !closing && !kd) return cst_pkg::ST_QUIET;
      if (ie && iv && sending && !closing) return cst_pkg::ST_SENDING;
      if (hr) return cst_pkg::ST_HARD_RESET;
      if (closing && !kd) return cst_pkg::ST_CLOSING;
      if (!closing && kd) return cst_pkg::ST_KILLED;
      if (closing && kd) return cst_pkg::ST_CLOSED_KILLED;
      return cst_pkg::ST_NONE;
    endfunction

    // Advance the connection machine one step; return the restart pulse
    function bit step_machine(logic [3:0] kind, bit rex, bit wex, bit closing);
      bit restart;
      restart = 1'b0;
      case (ph)
        cst_pkg::PH_CLOSED: begin
          if (kind == cst_pkg::FK_SYN && !open_pend) begin
            ph     = cst_pkg::PH_SYN_RCVD;
            cflags = cflags | CF_ESTABLISHING | CF_VERIFIED;
          end else if (kind == cst_pkg::FK_SYN) begin
            ph        = cst_pkg::PH_SYN_SENT;
            open_pend = 1'b0;
            cflags    = cflags | CF_SYNACK_DONE;
          end else begin
            cflags = cflags | CF_HARD_RESET;
          end
        end
        cst_pkg::PH_SYN_SENT: begin
          if (rex) begin
            ph = cst_pkg::PH_CLOSED;
          end else if (kind == cst_pkg::FK_SYN) begin
            ph = cst_pkg::PH_SYN_RCVD;
          end else if (kind == cst_pkg::FK_SYNACK) begin
            ph     = cst_pkg::PH_ESTAB;
            cflags = cflags | CF_IS_ESTAB | CF_VERIFIED;
          end
        end
        cst_pkg::PH_SYN_RCVD: begin
          if (kind == cst_pkg::FK_PSHACK || kind == cst_pkg::FK_ACK) begin
            ph = cst_pkg::PH_ESTAB;
            if (role == cst_pkg::ROLE_SECOND) begin
              cflags = (cflags & ~CF_ESTABLISHING) | CF_IS_ESTAB | CF_VERIFIED;
            end else if (role != cst_pkg::ROLE_FIRST && has(CF_ESTABLISHING)) begin
              cflags = cflags | CF_IS_ESTAB | CF_VERIFIED;
            end
          end else if (!rex && kind == cst_pkg::FK_RST) begin
            ph     = cst_pkg::PH_CLOSED;
            cflags = cflags & ~(CF_IS_ESTAB | CF_VERIFIED);
          end
        end
        cst_pkg::PH_ESTAB: begin
          if (kind == cst_pkg::FK_FIN) begin
            ph = cst_pkg::PH_FIN_WAIT;
            if (!closing) cflags = cflags | CF_KILLED;
          end else if (has(CF_HARD_RESET)) begin
            cflags  = cflags | CF_KILLED;
            ph      = cst_pkg::PH_TIME_WAIT;
            restart = 1'b1;
          end else if (kind == cst_pkg::FK_RST) begin
            ph      = cst_pkg::PH_TIME_WAIT;
            restart = 1'b1;
          end else if (closing) begin
            ph = cst_pkg::PH_FIN_WAIT;
          end
        end
        cst_pkg::PH_FIN_WAIT: begin
          if (kind == cst_pkg::FK_ACK) begin
            ph      = cst_pkg::PH_TIME_WAIT;
            cflags  = cflags | CF_KILLED;
            restart = 1'b1;
          end
        end
        cst_pkg::PH_TIME_WAIT: begin
          if (wex || kind == cst_pkg::FK_ACK) ph = cst_pkg::PH_CLOSED;
        end
        default: ;
      endcase
      return restart;
    endfunction

    // Check numbers, step on a match, queue the predicted verdict
    function void note_packet(cst_pkg::in_item_t p);
      cst_pkg::out_item_t v;
      logic [31:0]        len_sum;
      logic [1:0]         why;
      bit                 restart;
      if (p.open_request) open_pend = 1'b1;
      if (p.payload_length != 16'd0) last_len = p.payload_length;
      len_sum = p.ack_in + {16'd0, last_len};
      restart = 1'b0;
      if (seq_num != 32'd0 && len_sum != p.seq_in) why = cst_pkg::RSN_LENGTH;
      else if (ack_num != 32'd0 && p.ack_in != seq_num) why = cst_pkg::RSN_ACK;
      else why = cst_pkg::RSN_NONE;
      if (why == cst_pkg::RSN_NONE) begin
        seq_num = p.seq_in;
        ack_num = p.seq_in;
        restart = step_machine(p.flag_kind, p.retrans_expired, p.wait_expired,
                               p.close_request);
        n_stepped++;
        phases_seen[ph] = 1'b1;
      end else if (why == cst_pkg::RSN_LENGTH) begin
        n_len_rej++;
      end else begin
        n_ack_rej++;
      end
      v.accepted           = (why == cst_pkg::RSN_NONE);
      v.reject_reason      = why;
      v.conn_state         = ph;
      v.status_byte        = status_code(p.close_request, p.now_sending);
      v.restart_wait_timer = restart;
      v.seq_now            = seq_num;
      verdict_q = {verdict_q, v};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result against the oldest predicted verdict
    function void check_verdict(cst_pkg::out_item_t got);
      cst_pkg::out_item_t want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      compare_field("reject_reason", 32'(want.reject_reason), 32'(got.reject_reason));
      compare_field("conn_state", 32'(want.conn_state), 32'(got.conn_state));
      compare_field("status_byte", 32'(want.status_byte), 32'(got.status_byte));
      compare_field("restart_wait_timer", 32'(want.restart_wait_timer),
                    32'(got.restart_wait_timer));
      compare_field("seq_now", want.seq_now, got.seq_now);
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  cst_pkg::in_item_t  in_data   = '0;
  logic               out_ready = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [1:0]         paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic               in_ready;
  logic               out_valid;
  cst_pkg::out_item_t out_data;
  logic [31:0]        prdata;
  logic               pready;

  tracker_scoreboard sb = new();

  bit idle_on      = 1'b1;
  bit guard_closed = 1'b1;
  bit hold_request = 1'b0;
  bit valid_held   = 1'b0;
  int sent         = 0;
  int quiet_cycles = 0;

  connection_state_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run when no request moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_connection_state_tracker: done, errors");
      $finish;
    end
  end

  // Take results, stall in random bursts, hold off long on request
  initial begin : result_sink
    int stall_left;
    int long_left;
    stall_left = 0;
    long_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_verdict(out_data);
      if (hold_request) begin
        long_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (long_left > 0) begin
        long_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hold one request until accepted, then maybe drop valid for a burst
  task automatic offer(input cst_pkg::in_item_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    valid_held = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_packet(p);
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic release_valid();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  // Wait until every predicted verdict has come back
  task automatic settle();
    while (sb.verdict_q.size() != 0) @(posedge clk);
  endtask

  // Write node_role: setup cycle, then access cycle
  task automatic write_role(input logic [1:0] role);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cst_pkg::ADDR_NODE_ROLE;
    pwdata  <= {30'd0, role};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.role = role;
  endtask

  // Build a packet that passes both number checks
  function automatic cst_pkg::in_item_t well_formed(logic [3:0] kind);
    cst_pkg::in_item_t p;
    logic [15:0]       eff;
    p = '0;
    p.flag_kind = kind;
    p.ack_in    = sb.seq_num;
    case ($urandom_range(0, 3))
      0: p.payload_length = 16'd0;
      1: p.payload_length = 16'($urandom_range(1, 65535));
      default: p.payload_length = 16'($urandom_range(1, 255));
    endcase
    eff = (p.payload_length != 16'd0) ? p.payload_length : sb.last_len;
    p.seq_in = p.ack_in + {16'd0, eff};
    return p;
  endfunction

  task automatic directed(input logic [3:0] kind, input logic [4:0] ctl);
    cst_pkg::in_item_t p;
    p = well_formed(kind);
    {p.retrans_expired, p.wait_expired, p.open_request, p.close_request,
     p.now_sending} = ctl;
    offer(p);
  endtask

  // Mostly well-formed packets on useful kinds, a quarter noise
  function automatic cst_pkg::in_item_t random_request();
    cst_pkg::in_item_t p;
    logic [3:0]        kind;
    logic [31:0]       d;
    int                pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) kind = cst_pkg::FK_SYN;
    else if (pick < 6) kind = cst_pkg::FK_SYNACK;
    else if (pick < 10) kind = cst_pkg::FK_ACK;
    else if (pick < 12) kind = cst_pkg::FK_RST;
    else if (pick < 14) kind = cst_pkg::FK_PSHACK;
    else if (pick < 16) kind = cst_pkg::FK_FIN;
    else kind = 4'($urandom_range(0, 15));
    // keep the hard reset flag clear while guarded
    if (guard_closed && sb.ph == cst_pkg::PH_CLOSED) kind = cst_pkg::FK_SYN;
    p = well_formed(kind);
    case ($urandom_range(0, 11))
      0: begin
        p.seq_in         = $urandom;
        p.ack_in         = $urandom;
        p.payload_length = 16'($urandom);
      end
      1: begin
        d        = 32'd1 << $urandom_range(0, 31);
        p.ack_in = p.ack_in + d;
        p.seq_in = p.seq_in + d;
      end
      2: p.seq_in = p.seq_in + 32'($urandom_range(1, 65535));
      default: ;
    endcase
    p.retrans_expired = ($urandom_range(0, 5) == 0);
    p.wait_expired    = ($urandom_range(0, 3) == 0);
    p.open_request    = ($urandom_range(0, 2) == 0);
    p.close_request   = ($urandom_range(0, 3) == 0);
    p.now_sending     = 1'($urandom_range(0, 1));
    return p;
  endfunction

  task automatic run_phase(input logic [1:0] role, input int count, input bit guard,
                           input bit pressure);
    settle();
    write_role(role);
    guard_closed = guard;
    for (int i = 0; i < count; i++) begin
      if (pressure && i % 125 == 0) hold_request = 1'b1;
      offer(random_request());
    end
    release_valid();
  endtask

  initial begin : stimulus
    cst_pkg::in_item_t p;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Open at the top of the sequence space with everything else zero
    p = '0;
    p.seq_in    = 32'hFFFF_FF00;
    p.flag_kind = cst_pkg::FK_SYN;
    offer(p);
    // Wrap the stored sequence number to zero; a plain PSH holds syn rcvd
    p = well_formed(FLAG_PSH);
    p.payload_length  = 16'h0100;
    p.seq_in          = p.ack_in + 32'h0000_0100;
    p.retrans_expired = 1'b1;
    offer(p);
    // Stored numbers zero: any packet passes
    p = '1;
    p.flag_kind = FLAG_FINACK;
    p.retrans_expired = 1'b0;
    p.wait_expired    = 1'b0;
    p.open_request    = 1'b0;
    offer(p);
    // Acknowledge mismatch, then length mismatch
    p = well_formed(cst_pkg::FK_ACK);
    p.ack_in = p.ack_in + 32'd1;
    p.seq_in = p.seq_in + 32'd1;
    offer(p);
    p = well_formed(cst_pkg::FK_ACK);
    p.seq_in = p.seq_in + 32'd1;
    offer(p);
    // Walk the machine through every transition
    directed(cst_pkg::FK_ACK, CTL_SENDING);
    directed(cst_pkg::FK_RST, CTL_NONE);
    directed(cst_pkg::FK_SYN, CTL_NONE);
    directed(FLAG_OTHER, CTL_WAIT);
    directed(cst_pkg::FK_SYN, CTL_OPEN);
    directed(cst_pkg::FK_SYNACK, CTL_NONE);
    directed(FLAG_UNKNOWN, CTL_CLOSE);
    directed(cst_pkg::FK_ACK, CTL_NONE);
    directed(cst_pkg::FK_ACK, CTL_NONE);
    directed(cst_pkg::FK_SYN, CTL_OPEN);
    directed(cst_pkg::FK_SYNACK, CTL_RETRANS);
    directed(cst_pkg::FK_SYN, CTL_OPEN);
    directed(cst_pkg::FK_SYN, CTL_NONE);
    directed(cst_pkg::FK_RST, CTL_NONE);
    directed(cst_pkg::FK_SYN, CTL_NONE);
    directed(cst_pkg::FK_PSHACK, CTL_NONE);
    directed(cst_pkg::FK_FIN, CTL_NONE);
    directed(FLAG_OTHER2, CTL_SENDING);
    directed(cst_pkg::FK_ACK, CTL_NONE);
    directed(FLAG_TOP, CTL_WAIT);
    release_valid();

    // Random phases across every role; the last one runs without idling
    run_phase(cst_pkg::ROLE_FIRST, 250, 1'b1, 1'b0);
    run_phase(cst_pkg::ROLE_SECOND, 250, 1'b1, 1'b0);
    run_phase(ROLE_TOP, 250, 1'b0, 1'b1);
    idle_on = 1'b0;
    run_phase(cst_pkg::ROLE_RESET, 250, 1'b0, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d packets over node roles 0-3, %0d results checked", sent, sb.checked);
    $display("%0d stepped the machine, %0d length rejects, %0d ack rejects, phases seen %b",
             sb.n_stepped, sb.n_len_rej, sb.n_ack_rej, sb.phases_seen[5:0]);
    if (sb.errors == 0) begin
      $display("tb_connection_state_tracker: done, clean");
    end else begin
      $display("tb_connection_state_tracker: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cst_pkg.sv
rtl/core/cst_front.sv
rtl/core/cst_queue.sv
rtl/core/cst_back.sv
rtl/core/connection_state_tracker.sv
tb/sv/tb_connection_state_tracker.sv
